// File: hdl/erle_pkg.sv
package erle_pkg;

  localparam int OUT_BYTES_DEF = 8192;
  localparam int BYTE_W        = 8;
  localparam int COUNT_W       = 9;

  typedef enum logic [1:0] {
    PH_TAG   = 2'd0,
    PH_DATA  = 2'd1,
    PH_VALUE = 2'd2,
    PH_COUNT = 2'd3
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              stream_start;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_value;
    logic [COUNT_W-1:0] repeat_count;
    logic               last;
    logic               clamped;
  } out_item_t;

endpackage

// File: hdl/escape_rle_decoder.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_data  (in_byte, stream_start)
// out     | output    | out_valid / out_ready  | out_data (out_value, repeat_count, last, clamped)
//
// One encoded byte per cycle sustained while out_ready holds; the result is registered
// (input register, then decode into the result register).
// The phase machine and the produced-byte counter update in the decode cycle.
// Reset clears the phase to awaiting tag, the counter, the finished flag and
// both stage valids. A stalled result holds the decode stage, which in turn
// holds in_ready low only while the input register is also occupied.
module escape_rle_decoder
  import erle_pkg::*;
#(
  parameter int OUT_BYTES = OUT_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW = $clog2(OUT_BYTES + 1);
  localparam int SW = (CW > COUNT_W) ? CW : COUNT_W;

  logic              s1_valid;
  in_item_t          s1_data;
  logic              s1_go;

  phase_t            phase;
  phase_t            phase_next;
  logic [BYTE_W-1:0] escape_tag;
  logic [BYTE_W-1:0] escape_tag_next;
  logic [BYTE_W-1:0] run_value;
  logic [BYTE_W-1:0] run_value_next;
  logic [CW-1:0]     bytes_produced;
  logic [CW-1:0]     bytes_produced_next;
  logic              finished;
  logic              finished_next;

  logic              restart;
  logic              emit;
  logic [BYTE_W-1:0] emit_value;
  logic [SW-1:0]     req_count;
  logic [SW-1:0]     remain;
  logic [SW-1:0]     grant;
  logic [SW-1:0]     total;
  logic              clip;
  logic              done;
  out_item_t         result;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign restart  = s1_data.stream_start || (phase == PH_TAG);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  always_comb begin
    phase_next = phase;
    if (restart) begin
      phase_next = PH_DATA;
    end else if (!finished) begin
      case (phase)
        PH_DATA: begin
          if (s1_data.in_byte == escape_tag) begin
            phase_next = PH_VALUE;
          end
        end
        PH_VALUE: phase_next = PH_COUNT;
        PH_COUNT: phase_next = PH_DATA;
        default:  phase_next = PH_DATA;
      endcase
    end
  end

  always_comb begin
    emit       = 1'b0;
    emit_value = s1_data.in_byte;
    req_count  = SW'(1);
    if (!restart && !finished) begin
      case (phase)
        PH_DATA: begin
          emit = (s1_data.in_byte != escape_tag);
        end
        PH_COUNT: begin
          emit       = 1'b1;
          emit_value = run_value;
          req_count  = SW'(s1_data.in_byte) + SW'(1);
        end
        default: emit = 1'b0;
      endcase
    end

    remain = SW'(OUT_BYTES) - SW'(bytes_produced);
    clip   = req_count > remain;
    grant  = clip ? remain : req_count;
    total  = SW'(bytes_produced) + grant;
    done   = total >= SW'(OUT_BYTES);

    result.out_value    = emit_value;
    result.repeat_count = grant[COUNT_W-1:0];
    result.last         = done;
    result.clamped      = clip;

    escape_tag_next     = escape_tag;
    run_value_next      = run_value;
    bytes_produced_next = bytes_produced;
    finished_next       = finished;
    if (restart) begin
      escape_tag_next     = s1_data.in_byte;
      bytes_produced_next = '0;
      finished_next       = 1'b0;
    end else if (!finished) begin
      if (phase == PH_VALUE) begin
        run_value_next = s1_data.in_byte;
      end
      if (emit) begin
        bytes_produced_next = total[CW-1:0];
        finished_next       = done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TAG;
      escape_tag     <= '0;
      run_value      <= '0;
      bytes_produced <= '0;
      finished       <= 1'b0;
    end else if (s1_go) begin
      phase          <= phase_next;
      escape_tag     <= escape_tag_next;
      run_value      <= run_value_next;
      bytes_produced <= bytes_produced_next;
      finished       <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_data <= result;
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    bytes_produced <= CW'(OUT_BYTES))
    else $error("produced byte count passed the limit");

  a_finished_at_limit: assert property (@(posedge clk) disable iff (rst)
    finished == (bytes_produced == CW'(OUT_BYTES)))
    else $error("finished flag disagrees with produced byte count");

  a_clamp_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clamped |-> out_data.last)
    else $error("clamped result not marked last");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.repeat_count != '0)
    else $error("result with zero repeat count");

  a_no_result_when_finished: assert property (@(posedge clk) disable iff (rst)
    s1_go && finished && !restart |=> !out_valid)
    else $error("result after the output limit");

endmodule
